// ----- hw/rtl/ihex_pkg.sv -----
`timescale 1ns / 1ps

package ihex_pkg;

    // ascii codes
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;

    // record types
    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;

    // event codes
    localparam logic [1:0] EV_WRITE = 2'd0;
    localparam logic [1:0] EV_DONE  = 2'd1;
    localparam logic [1:0] EV_ERROR = 2'd2;

    typedef enum logic [9:0] {
        PH_IDLE    = 10'b00_0000_0001,
        PH_COMMENT = 10'b00_0000_0010,
        PH_COUNT   = 10'b00_0000_0100,
        PH_ADDR    = 10'b00_0000_1000,
        PH_TYPE    = 10'b00_0001_0000,
        PH_DATA    = 10'b00_0010_0000,
        PH_SKIP    = 10'b00_0100_0000,
        PH_TAIL    = 10'b00_1000_0000,
        PH_DONE    = 10'b01_0000_0000,
        PH_ERROR   = 10'b10_0000_0000
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [1:0]  digit_index;
        logic [7:0]  bytes_left;
        logic [15:0] load_address;
        logic [15:0] field_acc;
    } t_parse_state;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [15:0] write_address;
        logic [7:0]  write_byte;
    } t_out_word;

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_VT, CH_FF};
    endfunction

    function automatic logic is_eol(input logic [7:0] c);
        return (c == CH_LF) || (c == CH_CR);
    endfunction

    // returns {valid, nibble}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c inside {[8'h30:8'h39]}) begin
            d = c - 8'h30;
            return {1'b1, d[3:0]};
        end else if (c inside {[8'h41:8'h46]}) begin
            d = c - 8'h37;
            return {1'b1, d[3:0]};
        end else if (c inside {[8'h61:8'h66]}) begin
            d = c - 8'h57;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

endpackage

// ----- hw/rtl/ihex_step.sv -----
`timescale 1ns / 1ps

module ihex_step
    import ihex_pkg::*;
(
    input  t_parse_state i_state,
    input  t_in_word     i_word,
    output t_parse_state o_state,
    output logic         o_emit,
    output t_out_word    o_result
);

    logic [7:0]  c;
    logic [4:0]  hv;
    logic [15:0] acc_new;
    logic [1:0]  dig_new;
    logic        field_done;
    logic [7:0]  left_new;

    assign c        = i_word.char_code;
    assign hv       = hex_value(c);
    assign acc_new  = {i_state.field_acc[11:0], hv[3:0]};
    assign dig_new  = i_state.digit_index + 2'd1;
    // address field wraps the digit counter back to zero after four digits
    assign field_done = (i_state.phase == PH_ADDR) ? (dig_new == 2'd0) : (dig_new == 2'd2);
    assign left_new = i_state.bytes_left - 8'd1;

    always_comb begin
        o_state  = i_state;
        o_emit   = 1'b0;
        o_result = '0;
        if (i_state.phase inside {PH_DONE, PH_ERROR}) begin
            o_emit = 1'b0;
        end else if (i_word.end_of_input) begin
            o_emit = 1'b1;
            if (i_state.phase inside {PH_IDLE, PH_TAIL}) begin
                o_state.phase       = PH_DONE;
                o_result.event_kind = EV_DONE;
            end else begin
                o_state.phase       = PH_ERROR;
                o_result.event_kind = EV_ERROR;
            end
        end else begin
            case (i_state.phase)
                PH_IDLE: begin
                    if (is_blank(c)) begin
                        o_state.phase = PH_IDLE;
                    end else if (c == CH_SEMI) begin
                        o_state.phase = PH_COMMENT;
                    end else if (c == CH_COLON) begin
                        o_state.phase       = PH_COUNT;
                        o_state.digit_index = 2'd0;
                        o_state.field_acc   = 16'd0;
                    end else begin
                        o_state.phase       = PH_ERROR;
                        o_emit              = 1'b1;
                        o_result.event_kind = EV_ERROR;
                    end
                end
                PH_COMMENT, PH_SKIP, PH_TAIL: begin
                    if (is_eol(c)) begin
                        o_state.phase = PH_IDLE;
                    end
                end
                PH_COUNT, PH_ADDR, PH_TYPE, PH_DATA: begin
                    if (i_state.digit_index == 2'd0 && is_blank(c)) begin
                        o_state.phase = i_state.phase;
                    end else if (!hv[4]) begin
                        o_state.phase       = PH_ERROR;
                        o_emit              = 1'b1;
                        o_result.event_kind = EV_ERROR;
                    end else if (!field_done) begin
                        o_state.field_acc   = acc_new;
                        o_state.digit_index = dig_new;
                    end else begin
                        o_state.field_acc   = 16'd0;
                        o_state.digit_index = 2'd0;
                        case (i_state.phase)
                            PH_COUNT: begin
                                o_state.bytes_left = acc_new[7:0];
                                o_state.phase = (acc_new[7:0] == 8'd0) ? PH_SKIP : PH_ADDR;
                            end
                            PH_ADDR: begin
                                o_state.load_address = acc_new;
                                o_state.phase        = PH_TYPE;
                            end
                            PH_TYPE: begin
                                if (acc_new[7:0] == REC_EOF) begin
                                    o_state.phase       = PH_DONE;
                                    o_emit              = 1'b1;
                                    o_result.event_kind = EV_DONE;
                                end else if (acc_new[7:0] != REC_DATA) begin
                                    o_state.phase       = PH_ERROR;
                                    o_emit              = 1'b1;
                                    o_result.event_kind = EV_ERROR;
                                end else begin
                                    o_state.phase = PH_DATA;
                                end
                            end
                            default: begin
                                o_emit                 = 1'b1;
                                o_result.event_kind    = EV_WRITE;
                                o_result.write_address = i_state.load_address;
                                o_result.write_byte    = acc_new[7:0];
                                o_state.load_address   = i_state.load_address + 16'd1;
                                o_state.bytes_left     = left_new;
                                if (left_new == 8'd0) begin
                                    o_state.phase = PH_TAIL;
                                end
                            end
                        endcase
                    end
                end
                default: begin
                    o_state.phase       = PH_ERROR;
                    o_emit              = 1'b1;
                    o_result.event_kind = EV_ERROR;
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/intel_hex_record_parser_core.sv -----
`timescale 1ns / 1ps
// intel hex record parser, one text character per input word
// input channel: i_in_valid / o_in_ready carry a t_in_word (char_code plus an
//   end_of_input mark whose char_code is ignored)
// output channel: o_out_valid / i_out_ready carry a t_out_word event: a memory
//   write of write_byte at write_address, load finished, or parse error
// each word causes zero or one event; blanks between fields, comments, digits
//   before the last of a field and the checksum tail cause none
// an accepted word waits in the input register until the result slot is free;
//   it is then parsed and its event is offered from the result register
// throughput: one word per cycle unless the receiver stalls; the single parse
//   stage updates the record state between the input and result registers
// when the receiver stalls, the event holds in the result register; the input
//   register takes one more word only if empty, then o_in_ready drops until the
//   result is taken
// done and error are sticky: later words are accepted and dropped
// reset (synchronous, active low) empties both registers and returns the
//   parser to waiting for a record start
module intel_hex_record_parser_core
    import ihex_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    logic         r_in_valid;
    t_in_word     r_in_word;
    t_parse_state r_state, n_state;
    logic         r_out_valid;
    t_out_word    r_out_word, n_out_word;
    logic         step_emit;
    logic         can_proc;
    logic         proc;

    // result slot is free or being emptied this cycle
    assign can_proc   = !r_out_valid || i_out_ready;
    assign proc       = r_in_valid && can_proc;
    assign o_in_ready = !r_in_valid || can_proc;

    ihex_step u_step (
        .i_state  (r_state),
        .i_word   (r_in_word),
        .o_state  (n_state),
        .o_emit   (step_emit),
        .o_result (n_out_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{phase: PH_IDLE, digit_index: 2'd0, bytes_left: 8'd0,
                             load_address: 16'd0, field_acc: 16'd0};
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (proc) begin
                r_state <= n_state;
            end
            if (can_proc) begin
                r_out_valid <= proc && step_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
        if (proc && step_emit) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // finished phases are sticky
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == PH_DONE |=> r_state.phase == PH_DONE)
        else $error("done phase left without reset");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == PH_ERROR |=> r_state.phase == PH_ERROR)
        else $error("error phase left without reset");

    // a pending done or error event matches the parser state
    a_done_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.event_kind == EV_DONE |-> r_state.phase == PH_DONE)
        else $error("done event while parser not finished");

    a_error_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.event_kind == EV_ERROR |-> r_state.phase == PH_ERROR)
        else $error("error event while parser not in error");

    // a word waiting for a full result slot is not lost
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !can_proc |=> r_in_valid && $stable(r_in_word))
        else $error("pending input word dropped");

endmodule
